### src/dsm2_rle_pkg.sv
// ----------------------------------------------------------------------------
// dsm2_rle_pkg
// Shared types and constants for the serial frame run-length encoder.
// ----------------------------------------------------------------------------
package dsm2_rle_pkg;

    localparam int CHANNELS_DEFAULT      = 6;
    localparam int TICKS_PER_BIT_DEFAULT = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_LINK_MODE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODEL_NUMBER = 1'd1;

    localparam logic [1:0] MODE_BASIC = 2'd0;
    localparam logic [1:0] MODE_PLAIN = 2'd1;

    localparam logic [7:0] HEADER_BASIC    = 8'h80;
    localparam logic [7:0] HEADER_PLAIN    = 8'h90;
    localparam logic [7:0] HEADER_EXTENDED = 8'h98;
    localparam logic [7:0] HEADER_UNSET    = 8'h47;
    localparam logic [7:0] HEADER_RESET    = 8'hFF;
    localparam int         BIND_POS        = 7;
    localparam int         RANGE_POS       = 5;

    localparam logic [10:0] PULSE_OFFSET = 11'd512;
    localparam logic [10:0] PULSE_LIMIT  = 11'd1536;
    localparam logic [9:0]  PULSE_MAX    = 10'd1023;

    localparam int         SYMBOL_BITS = 10;
    localparam logic [7:0] FINAL_TICKS = 8'd255;

    typedef struct packed {
        logic              kind;
        logic              trainer_pulled;
        logic              range_switch;
        logic [2:0]        channel_index;
        logic signed [11:0] channel_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] run_ticks;
        logic       line_level;
        logic       frame_end;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       frame_end;
    } job_t;

endpackage

### src/dsm2_frame_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the job queue, and its first run is
// then registered on m_data when the serialiser is idle and the result side
// is not stalled. Throughput: one run per cycle from the serialiser while the
// result side is not stalled; an item gives 4 to 20 runs from its two bytes.
// Reset: the stored header returns to 0xFF, both registers clear to zero and
// the job queue and the result register empty.
// ----------------------------------------------------------------------------
// dsm2_frame_run_length_encoder_top
// Serial frame run-length encoder: front classifier, job queue and run
// serialiser.
// ----------------------------------------------------------------------------
module dsm2_frame_run_length_encoder_top #(
    parameter int CHANNELS      = dsm2_rle_pkg::CHANNELS_DEFAULT,
    parameter int TICKS_PER_BIT = dsm2_rle_pkg::TICKS_PER_BIT_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dsm2_rle_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dsm2_rle_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  dsm2_rle_pkg::in_item_t                s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output dsm2_rle_pkg::out_item_t               m_data
);
    import dsm2_rle_pkg::*;

    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic queue_valid;
    logic queue_ready;
    job_t queue_job;

    dsm2_rle_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job_data  (front_job)
    );

    dsm2_rle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_job),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_data  (queue_job)
    );

    dsm2_rle_back #(
        .TICKS_PER_BIT (TICKS_PER_BIT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (queue_valid),
        .job_ready (queue_ready),
        .job_data  (queue_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### src/dsm2_rle_front.sv
// ----------------------------------------------------------------------------
// dsm2_rle_front
// Accepts input items, keeps the header state and the configuration, and
// turns each item into a pair of bytes for the serialiser.
// ----------------------------------------------------------------------------
module dsm2_rle_front #(
    parameter int CHANNELS = dsm2_rle_pkg::CHANNELS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dsm2_rle_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dsm2_rle_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  dsm2_rle_pkg::in_item_t                s_data,
    output logic                                  job_valid,
    input  logic                                  job_ready,
    output dsm2_rle_pkg::job_t                    job_data
);
    import dsm2_rle_pkg::*;

    logic [7:0]  header_reg;
    logic [7:0]  header_next;
    logic [1:0]  link_mode_reg;
    logic [7:0]  model_number_reg;
    logic [7:0]  hdr;
    logic [11:0] biased;
    logic [10:0] half;
    logic [9:0]  pulse;
    logic        accept;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;

    always_comb begin
        hdr = header_reg;
        if ((hdr & HEADER_UNSET) != 8'd0) begin
            case (link_mode_reg)
                MODE_BASIC: hdr = HEADER_BASIC;
                MODE_PLAIN: hdr = HEADER_PLAIN;
                default:    hdr = HEADER_EXTENDED;
            endcase
        end
        if (hdr[BIND_POS] && !s_data.trainer_pulled) begin
            hdr[BIND_POS] = 1'b0;
        end
        hdr[RANGE_POS] = !hdr[BIND_POS] && s_data.range_switch;
    end

    always_comb begin
        biased = {~s_data.channel_value[11], s_data.channel_value[10:0]};
        half   = biased[11:1];
        if (half < PULSE_OFFSET) begin
            pulse = 10'd0;
        end else if (half >= PULSE_LIMIT) begin
            pulse = PULSE_MAX;
        end else begin
            pulse = 10'(half - PULSE_OFFSET);
        end
    end

    always_comb begin
        if (!s_data.kind) begin
            job_data.byte0     = hdr;
            job_data.byte1     = model_number_reg + 8'd1;
            job_data.frame_end = 1'b0;
        end else begin
            job_data.byte0     = {3'b000, s_data.channel_index, pulse[9:8]};
            job_data.byte1     = pulse[7:0];
            job_data.frame_end = (s_data.channel_index == 3'(CHANNELS - 1));
        end
    end

    always_comb begin
        header_next = header_reg;
        if (accept && !s_data.kind) begin
            header_next = hdr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg       <= HEADER_RESET;
            link_mode_reg    <= MODE_BASIC;
            model_number_reg <= 8'd0;
        end else begin
            header_reg <= header_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LINK_MODE:    link_mode_reg    <= cfg_wdata[1:0];
                    REG_MODEL_NUMBER: model_number_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

### src/dsm2_rle_queue.sv
// ----------------------------------------------------------------------------
// dsm2_rle_queue
// Two-entry queue of byte-pair jobs between the front and the serialiser.
// ----------------------------------------------------------------------------
module dsm2_rle_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  dsm2_rle_pkg::job_t wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output dsm2_rle_pkg::job_t rd_data
);
    import dsm2_rle_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/dsm2_rle_back.sv
// ----------------------------------------------------------------------------
// dsm2_rle_back
// Serialises byte pairs as 8N1 line runs, one run per cycle while the output
// is not stalled, into a registered result output.
// ----------------------------------------------------------------------------
module dsm2_rle_back #(
    parameter int TICKS_PER_BIT = dsm2_rle_pkg::TICKS_PER_BIT_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  dsm2_rle_pkg::job_t      job_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output dsm2_rle_pkg::out_item_t m_data
);
    import dsm2_rle_pkg::*;

    logic                   active_reg;
    logic                   active_next;
    logic                   second_reg;
    logic                   second_next;
    logic [SYMBOL_BITS-1:0] vec_reg;
    logic [SYMBOL_BITS-1:0] vec_next;
    logic [3:0]             cnt_reg;
    logic [3:0]             cnt_next;
    logic [7:0]             byte1_reg;
    logic [7:0]             byte1_next;
    logic                   frame_reg;
    logic                   frame_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    out_item_t              m_data_reg;
    out_item_t              m_data_next;

    logic [SYMBOL_BITS-1:0] cur_vec;
    logic [3:0]             cur_cnt;
    logic                   cur_second;
    logic [7:0]             cur_byte1;
    logic                   cur_frame;
    logic [3:0]             run_len;
    logic                   found;
    logic                   final_run;
    logic [3:0]             run_bits;
    logic [8:0]             run_product;
    logic                   out_free;
    logic                   emit;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = out_free && (active_reg || job_valid);
    assign job_ready = out_free && !active_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        if (active_reg) begin
            cur_vec    = vec_reg;
            cur_cnt    = cnt_reg;
            cur_second = second_reg;
            cur_byte1  = byte1_reg;
            cur_frame  = frame_reg;
        end else begin
            cur_vec    = {1'b1, job_data.byte0, 1'b0};
            cur_cnt    = 4'(SYMBOL_BITS);
            cur_second = 1'b0;
            cur_byte1  = job_data.byte1;
            cur_frame  = job_data.frame_end;
        end
    end

    always_comb begin
        run_len = cur_cnt;
        found   = 1'b0;
        for (int i = 1; i < SYMBOL_BITS; i++) begin
            if (!found && ((4'(i) >= cur_cnt) || (cur_vec[i] != cur_vec[0]))) begin
                run_len = 4'(i);
                found   = 1'b1;
            end
        end
        final_run   = (run_len == cur_cnt);
        run_bits    = run_len + 4'(final_run);
        run_product = 9'(run_bits) * 9'(TICKS_PER_BIT) - 9'd1;
    end

    always_comb begin
        m_data_next.line_level = cur_vec[0];
        m_data_next.last       = final_run && cur_second;
        m_data_next.frame_end  = final_run && cur_second && cur_frame;
        if (m_data_next.frame_end) begin
            m_data_next.run_ticks = FINAL_TICKS;
        end else begin
            m_data_next.run_ticks = run_product[7:0];
        end
    end

    always_comb begin
        active_next  = active_reg;
        second_next  = second_reg;
        vec_next     = vec_reg;
        cnt_next     = cnt_reg;
        byte1_next   = byte1_reg;
        frame_next   = frame_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next = 1'b1;
            byte1_next   = cur_byte1;
            frame_next   = cur_frame;
            if (final_run) begin
                if (!cur_second) begin
                    active_next = 1'b1;
                    second_next = 1'b1;
                    vec_next    = {1'b1, cur_byte1, 1'b0};
                    cnt_next    = 4'(SYMBOL_BITS);
                end else begin
                    active_next = 1'b0;
                    second_next = 1'b0;
                end
            end else begin
                active_next = 1'b1;
                second_next = cur_second;
                vec_next    = cur_vec >> run_len;
                cnt_next    = cur_cnt - run_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        vec_reg   <= vec_next;
        cnt_reg   <= cnt_next;
        byte1_reg <= byte1_next;
        frame_reg <= frame_next;
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### tb/sv/tb_dsm2_frame_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_dsm2_frame_run_length_encoder_top
// Self-checking bench for the serial frame run-length encoder. Header and
// channel items are driven through the input handshake with random gaps,
// the run stream is taken with random stalls, and every run is checked
// against a predictor that codes each byte 8N1 into merged line runs.
// ----------------------------------------------------------------------------
import dsm2_rle_pkg::*;

localparam logic       KIND_HEADER   = 1'b0;
localparam logic       KIND_CHANNEL  = 1'b1;
localparam logic [1:0] MODE_EXTENDED = 2'd2;
localparam logic [1:0] MODE_ALIAS    = 2'd3;
localparam int         TICKS         = TICKS_PER_BIT_DEFAULT;
localparam int         LAST_CHANNEL  = CHANNELS_DEFAULT - 1;

class run_length_tracker;
    out_item_t  pending_runs[$];
    logic [7:0] header_byte;
    logic [1:0] link_mode;
    logic [7:0] model_number;
    int         mismatches;

    function new();
        header_byte  = HEADER_RESET;
        link_mode    = MODE_BASIC;
        model_number = '0;
        mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
        if (idx == REG_LINK_MODE) begin
            link_mode = data[1:0];
        end else if (idx == REG_MODEL_NUMBER) begin
            model_number = data;
        end
    endfunction

    function void add_run(int span, logic level);
        out_item_t r;
        r.run_ticks  = 8'(span - 1);
        r.line_level = level;
        r.frame_end  = 1'b0;
        r.last       = 1'b0;
        pending_runs.push_back(r);
    endfunction

    function void code_byte(logic [7:0] value);
        logic [7:0] bits;
        logic       level;
        int         span;
        bits  = value;
        level = 1'b0;
        span  = TICKS;
        for (int k = 0; k <= 8; k++) begin
            if (bits[0] == level) begin
                span += TICKS;
            end else begin
                add_run(span, level);
                span  = TICKS;
                level = bits[0];
            end
            bits = {1'b1, bits[7:1]};
        end
        add_run(span + TICKS, level);
    endfunction

    function void note_item(in_item_t item);
        logic [7:0]  h;
        logic [7:0]  second;
        logic [11:0] biased;
        logic [10:0] half;
        logic [9:0]  pulse;
        out_item_t   r;
        if (item.kind == KIND_HEADER) begin
            h = header_byte;
            if ((h & HEADER_UNSET) != 8'h00) begin
                if (link_mode == MODE_BASIC) begin
                    h = HEADER_BASIC;
                end else if (link_mode == MODE_PLAIN) begin
                    h = HEADER_PLAIN;
                end else begin
                    h = HEADER_EXTENDED;
                end
            end
            if (h[BIND_POS] && !item.trainer_pulled) begin
                h[BIND_POS] = 1'b0;
            end
            if (!h[BIND_POS] && item.range_switch) begin
                h[RANGE_POS] = 1'b1;
            end else begin
                h[RANGE_POS] = 1'b0;
            end
            header_byte = h;
            second      = model_number + 8'd1;
            code_byte(h);
            code_byte(second);
        end else begin
            biased = item.channel_value ^ 12'h800;
            half   = biased[11:1];
            if (half < PULSE_OFFSET) begin
                pulse = '0;
            end else if (half >= PULSE_LIMIT) begin
                pulse = PULSE_MAX;
            end else begin
                pulse = 10'(half - PULSE_OFFSET);
            end
            code_byte({3'b000, item.channel_index, pulse[9:8]});
            code_byte(pulse[7:0]);
        end
        r = pending_runs.pop_back();
        if (item.kind == KIND_CHANNEL && item.channel_index == 3'(LAST_CHANNEL)) begin
            r.run_ticks = FINAL_TICKS;
            r.frame_end = 1'b1;
        end
        r.last = 1'b1;
        pending_runs.push_back(r);
    endfunction

    function void check_run(out_item_t got);
        out_item_t want;
        if (pending_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected run at %0t: ticks %0d level %0b end %0b last %0b",
                         $time, got.run_ticks, got.line_level, got.frame_end, got.last);
            end
            return;
        end
        want = pending_runs.pop_front();
        if (got.run_ticks !== want.run_ticks || got.line_level !== want.line_level ||
            got.frame_end !== want.frame_end || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Run mismatch at %0t: expected ticks %0d level %0b end %0b last %0b",
                         $time, want.run_ticks, want.line_level, want.frame_end, want.last);
                $display("                      got ticks %0d level %0b end %0b last %0b",
                         got.run_ticks, got.line_level, got.frame_end, got.last);
            end
        end
    endfunction
endclass

module tb_dsm2_frame_run_length_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;

    run_length_tracker tracker = new();
    bit send_calm = 1'b0;
    bit take_calm = 1'b0;
    int accepted_items = 0;

    always #5 aclk = ~aclk;

    dsm2_frame_run_length_encoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic in_item_t make_item(logic kind, logic trainer, logic range_sw,
                                           logic [2:0] idx, logic [11:0] value);
        in_item_t item;
        item.kind           = kind;
        item.trainer_pulled = trainer;
        item.range_switch   = range_sw;
        item.channel_index  = idx;
        item.channel_value  = value;
        return item;
    endfunction

    function automatic logic [11:0] draw_value();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 4095);
            1: v = $urandom_range(0, 1) ? $urandom_range(1000, 1100) : -$urandom_range(1000, 1100);
            default: v = $urandom_range(0, 2200) - 1100;
        endcase
        return v[11:0];
    endfunction

    task automatic send_item(in_item_t item);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(item);
        accepted_items++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending_runs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Both registers are written back to back while the block is idle.
    task automatic configure(logic [7:0] mode_word, logic [7:0] model);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LINK_MODE;
        cfg_wdata <= mode_word;
        @(posedge aclk);
        tracker.set_reg(REG_LINK_MODE, mode_word);
        cfg_index <= REG_MODEL_NUMBER;
        cfg_wdata <= model;
        @(posedge aclk);
        tracker.set_reg(REG_MODEL_NUMBER, model);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame();
        send_item(make_item(KIND_HEADER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095))));
        for (int ch = 0; ch <= LAST_CHANNEL; ch++) begin
            send_item(make_item(KIND_CHANNEL, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 3'(ch), draw_value()));
        end
    endtask

    initial begin
        int       stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap(take_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_run(m_data);
        end
    end

    initial begin
        logic [7:0] mode_word;
        logic [7:0] model;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure({6'b0, MODE_ALIAS}, 8'd255);
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b0, 3'd0, 12'h000));
        send_item(make_item(KIND_HEADER, 1'b1, 1'b1, 3'd0, 12'h000));
        send_item(make_item(KIND_HEADER, 1'b1, 1'b0, 3'd7, 12'hFFF));
        send_item(make_item(KIND_CHANNEL, 1'b1, 1'b1, 3'd1, 12'h800));
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b0, 3'd2, 12'h7FF));
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b1, 3'd3, 12'hC00));
        send_item(make_item(KIND_CHANNEL, 1'b1, 1'b0, 3'd4, 12'h3FF));
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b0, 3'd5, 12'hFFF));
        send_item(make_item(KIND_HEADER, 1'b0, 1'b1, 3'd0, 12'h000));
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b0, 3'd6, 12'h001));
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b0, 3'd7, 12'hBFF));
        send_item(make_item(KIND_HEADER, 1'b0, 1'b0, 3'd0, 12'h000));
        send_item(make_item(KIND_HEADER, 1'b1, 1'b1, 3'd0, 12'h000));
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b0, 3'd5, 12'h7FF));
        send_item(make_item(KIND_CHANNEL, 1'b0, 1'b0, 3'd5, 12'h800));
        drain();
        configure({6'b0, MODE_BASIC}, 8'd0);
        send_item(make_item(KIND_HEADER, 1'b1, 1'b0, 3'd0, 12'h000));
        drain();
        configure({6'b0, MODE_PLAIN}, 8'd254);
        send_item(make_item(KIND_HEADER, 1'b0, 1'b1, 3'd0, 12'h000));
        drain();
        configure({6'b0, MODE_EXTENDED}, 8'd128);

        while (accepted_items < 160) begin
            drain();
            mode_word = $urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: model = 8'd0;
                1: model = 8'd254;
                2: model = 8'd255;
                default: model = 8'($urandom_range(0, 255));
            endcase
            configure(mode_word, model);
            send_calm = ($urandom_range(0, 3) == 0);
            take_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 4)) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_frame();
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                            12'($urandom_range(0, 4095))));
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (tracker.pending_runs.size() != 0) begin
            $display("%0d expected runs never arrived", tracker.pending_runs.size());
        end
        if (tracker.mismatches == 0 && tracker.pending_runs.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: simulation limit reached");
        $display("FAIL");
        $finish;
    end
endmodule

### sim.f
src/dsm2_rle_pkg.sv
src/dsm2_rle_front.sv
src/dsm2_rle_queue.sv
src/dsm2_rle_back.sv
src/dsm2_frame_run_length_encoder_top.sv
tb/sv/tb_dsm2_frame_run_length_encoder_top.sv
